FILE: hw/rtl/fir_osd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_osd_pkg
// Shared widths and types of the direct-form FIR filter with one-sample lag.
// ----------------------------------------------------------------------------
package fir_osd_pkg;

  // Number of coefficient registers; taps beyond the configured count are
  // stored but never enter the sum.
  localparam int unsigned NUM_COEFS = 8;
  localparam int unsigned COEF_IDX_W = 3;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic        [CFG_DAT_W-1:0] cfg_dat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fir_osd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_osd_if
// Valid/ready channels of the FIR filter: input samples, result sums and
// coefficient register writes.
// ----------------------------------------------------------------------------

// Input sample channel.
interface fir_osd_in_if;
  import fir_osd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// Result channel.
interface fir_osd_out_if;
  import fir_osd_pkg::*;
  logic valid;
  logic ready;
  sum_t sum_out;

  modport source (output valid, output sum_out, input ready);
  modport sink   (input valid, input sum_out, output ready);
endinterface

// Coefficient register write channel.
interface fir_osd_cfg_if;
  import fir_osd_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_dat_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fir_filter_one_sample_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_one_sample_delay
// Direct-form FIR filter whose sum uses the delay line before the new sample
// is shifted in, so the output lags the input by one sample.
// ----------------------------------------------------------------------------
// The filter takes one item at a time and works through it in steps: it
// accepts the sample, issues one read per tap through the single delay-line
// memory read port into the one shared multiply-accumulate, drains the read
// and multiply stages, and loads the result register. The delay line is a
// circular buffer in a small synchronous memory; per-entry valid bits make
// it read as zero after reset. The result register lets a finished sum wait
// for the sink while the next sample is accepted. If the previous sum is
// still waiting when the next one is done, the filter holds in its output
// state until the sink takes it. Coefficient writes are always accepted;
// indexes of eight or more are ignored.
module fir_filter_one_sample_delay
  import fir_osd_pkg::*;
#(
  parameter int unsigned TAPS = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  fir_osd_in_if.sink        sample_i,
  fir_osd_out_if.source     sum_o,
  fir_osd_cfg_if.sink       cfg_i
);

  localparam int unsigned AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]    state_q;
  logic [AW-1:0] tap_q;
  logic [AW-1:0] rd_ptr_q;
  logic [AW-1:0] wr_ptr_q;
  coef_t         coef_q [NUM_COEFS];
  sample_t       mem [TAPS];
  logic          mem_vld_q [TAPS];
  sample_t       new_sample_q;

  logic          st1_vld_q, st1_last_q, st1_ok_q;
  sample_t       st1_data_q;
  coef_t         st1_coef_q;
  logic          st2_vld_q, st2_last_q;
  prod_t         st2_prod_q;
  sum_t          acc_q;
  logic          out_vld_q;
  sum_t          out_sum_q;

  logic          in_acc, out_take, issue, load_out;
  sample_t       st1_operand;

  assign in_acc   = sample_i.valid && sample_i.ready;
  assign out_take = out_vld_q && sum_o.ready;
  assign issue    = (state_q == ST_RUN);
  assign load_out = (state_q == ST_OUT) && (!out_vld_q || sum_o.ready);

  assign sample_i.ready = (state_q == ST_IDLE);
  assign sum_o.valid    = out_vld_q;
  assign sum_o.sum_out  = out_sum_q;
  assign cfg_i.ready    = 1'b1;

  // Entries never written since reset count as zero.
  assign st1_operand = st1_ok_q ? st1_data_q : '0;

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_COEFS))) begin
      coef_q[cfg_i.index[COEF_IDX_W-1:0]] <= cfg_i.data;
    end
  end

  // Sequencer, pointers and pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tap_q      <= '0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      st1_vld_q  <= 1'b0;
      st1_last_q <= 1'b0;
      st2_vld_q  <= 1'b0;
      st2_last_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        mem_vld_q[i] <= 1'b0;
      end
    end else begin
      st1_vld_q  <= issue;
      st1_last_q <= issue && (tap_q == LAST_TAP);
      st2_vld_q  <= st1_vld_q;
      st2_last_q <= st1_last_q;

      // A taken sum frees the result register unless a new one loads.
      if (out_take && !load_out) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q  <= ST_RUN;
            tap_q    <= '0;
            // Most recent stored sample sits just below the write pointer.
            rd_ptr_q <= (wr_ptr_q == '0) ? LAST_TAP : wr_ptr_q - 1'b1;
          end
        end
        ST_RUN: begin
          rd_ptr_q <= (rd_ptr_q == '0) ? LAST_TAP : rd_ptr_q - 1'b1;
          if (tap_q == LAST_TAP) begin
            state_q <= ST_WAIT;
          end else begin
            tap_q <= tap_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (st2_vld_q && st2_last_q) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            out_vld_q           <= 1'b1;
            mem_vld_q[wr_ptr_q] <= 1'b1;
            wr_ptr_q            <= (wr_ptr_q == LAST_TAP) ? '0 : wr_ptr_q + 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Delay-line memory: one registered read per tap, the new sample written
  // over the oldest entry once all reads are done.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mem[wr_ptr_q] <= new_sample_q;
    end
    st1_data_q <= mem[rd_ptr_q];
  end

  // Datapath: read stage, multiply stage, accumulate and result register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_sample_q <= sample_i.sample_in;
    end
    st1_ok_q   <= mem_vld_q[rd_ptr_q];
    st1_coef_q <= coef_q[COEF_IDX_W'(tap_q)];
    st2_prod_q <= st1_operand * st1_coef_q;
    if (in_acc) begin
      acc_q <= '0;
    end else if (st2_vld_q) begin
      acc_q <= acc_q + SUM_W'(st2_prod_q);
    end
    if (load_out) begin
      out_sum_q <= acc_q;
    end
  end

endmodule
`default_nettype wire
